>>> rtl/urxrb_pkg.sv
// Package for the serial receive ring buffer: opcodes, character codes,
// default depth and the controller-to-datapath command word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urxrb_pkg;

    localparam int unsigned DEFAULT_RING_DEPTH = 16;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FILL_W   = 4;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] EMPTY_CODE = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming word and launch the ring read
        logic execute;  // apply the operation and load the result register
    } ctl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/uart_rx_ring_buffer.sv
// Receive FIFO of a serial port: ring of RING_DEPTH bytes, one slot kept empty.
// An accepted word is captured (opcode, byte, ring read), then executed into the
// result register once that register is free; no new word is taken meanwhile.
// A new word is taken while the previous result still waits.
// Reset: pointers to zero (ring empty), line-end notify off, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_ring_buffer #(
    parameter int unsigned RING_DEPTH = urxrb_pkg::DEFAULT_RING_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration: line-end notify enable
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_wr_data,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [urxrb_pkg::OP_W-1:0]     opcode,
    input  wire logic [urxrb_pkg::BYTE_W-1:0]   rx_byte,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [urxrb_pkg::BYTE_W-1:0]        read_byte,
    output logic                                had_byte,
    output logic [urxrb_pkg::FILL_W-1:0]        fill_count,
    output logic                                line_end,
    output logic                                dropped
);
    import urxrb_pkg::*;

    ctl_cmd_t cmd;

    // Controller: take a word when idle, then execute it once the result
    // register is free (empty, or being drained this cycle).
    urxrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: capture launches the ring read at the read pointer; execute
    // decodes the opcode, writes a pushed byte, advances a pointer and
    // loads the result fields.
    urxrb_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (opcode),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .read_byte   (read_byte),
        .had_byte    (had_byte),
        .fill_count  (fill_count),
        .line_end    (line_end),
        .dropped     (dropped)
    );

endmodule

`default_nettype wire

>>> rtl/urxrb_ctrl.sv
// Controller of the serial receive ring buffer: sequences capture and
// execute of one word at a time and owns the result valid flag.
// Depends on urxrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urxrb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output urxrb_pkg::ctl_cmd_t     cmd
);
    import urxrb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the new word
                if (out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("capture did not move controller to execute");

    a_execute_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid_reg)
        else $error("executed word produced no valid result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.execute)
        else $error("stalled result overwritten");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

`default_nettype wire

>>> rtl/urxrb_datapath.sv
// Datapath of the serial receive ring buffer: byte ring memory, pointers,
// notify register and the result register.
// Depends on urxrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urxrb_datapath #(
    parameter int unsigned RING_DEPTH = urxrb_pkg::DEFAULT_RING_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire urxrb_pkg::ctl_cmd_t            cmd,
    input  wire logic [urxrb_pkg::OP_W-1:0]     opcode,
    input  wire logic [urxrb_pkg::BYTE_W-1:0]   rx_byte,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_wr_data,
    output logic [urxrb_pkg::BYTE_W-1:0]        read_byte,
    output logic                                had_byte,
    output logic [urxrb_pkg::FILL_W-1:0]        fill_count,
    output logic                                line_end,
    output logic                                dropped
);
    import urxrb_pkg::*;

    localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
    localparam int unsigned FILL_X = (PTR_W > FILL_W) ? PTR_W : FILL_W;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [PTR_W-1:0]  rp_reg;
    logic [PTR_W-1:0]  rp_next;
    logic              notify_reg;

    logic [BYTE_W-1:0] read_byte_reg;
    logic [BYTE_W-1:0] read_byte_next;
    logic              had_byte_reg;
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    logic              line_end_reg;
    logic              line_end_next;
    logic              dropped_reg;
    logic              dropped_next;

    logic              nonempty;
    logic              full;
    logic [PTR_W-1:0]  wp_inc;
    logic [PTR_W-1:0]  rp_inc;
    logic              mem_we;
    logic [PTR_W-1:0]  fill_ptr;
    logic [FILL_X-1:0] fill_ext;

    assign wp_inc   = wp_reg + PTR_W'(1);
    assign rp_inc   = rp_reg + PTR_W'(1);
    assign nonempty = (rp_reg != wp_reg);
    assign full     = (wp_inc == rp_reg);

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        read_byte_next = '0;
        line_end_next  = 1'b0;
        dropped_next   = 1'b0;
        mem_we         = 1'b0;
        unique case (op_reg) inside
            OP_PUSH:
            begin
                if (!full)
                begin
                    wp_next       = wp_inc;
                    mem_we        = cmd.execute;
                    line_end_next = notify_reg &&
                                    (byte_reg == CHAR_LF || byte_reg == CHAR_CR);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
            end
            OP_PEEK, OP_GET:
            begin
                if (nonempty)
                begin
                    read_byte_next = rd_data_reg;
                    if (op_reg == OP_GET)
                    begin
                        rp_next = rp_inc;
                    end
                end
                else
                begin
                    read_byte_next = EMPTY_CODE;
                end
            end
            OP_STATUS:
            begin
                read_byte_next = '0;
            end
            default:
            begin
                read_byte_next = '0;
            end
        endcase
    end

    // occupancy after the operation, reported modulo the port width
    assign fill_ptr        = wp_next - rp_next;
    assign fill_ext        = FILL_X'(fill_ptr);
    assign fill_count_next = fill_ext[FILL_W-1:0];

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wp_reg] <= byte_reg;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= ring_mem[rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            byte_reg <= rx_byte;
        end
        if (cmd.execute)
        begin
            read_byte_reg  <= read_byte_next;
            had_byte_reg   <= nonempty;
            fill_count_reg <= fill_count_next;
            line_end_reg   <= line_end_next;
            dropped_reg    <= dropped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            notify_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                wp_reg <= wp_next;
                rp_reg <= rp_next;
            end
            if (cfg_wr_en)
            begin
                notify_reg <= cfg_wr_data;
            end
        end
    end

    assign read_byte  = read_byte_reg;
    assign had_byte   = had_byte_reg;
    assign fill_count = fill_count_reg;
    assign line_end   = line_end_reg;
    assign dropped    = dropped_reg;

    a_ptrs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> ($stable(wp_reg) && $stable(rp_reg)))
        else $error("pointer moved without an executed word");

    a_one_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.execute && (wp_next != wp_reg) && (rp_next != rp_reg)))
        else $error("both pointers advanced in one operation");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && full) |-> !mem_we)
        else $error("write into a full ring");

endmodule

`default_nettype wire
